[hdl/tbs_pkg.sv]
// shared types and constants for the terrain brush sculpt block
// no dependencies
package tbs_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned TimeW     = 17;
  localparam int unsigned RegW      = 31;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned QuotW     = 31;

  localparam logic [1:0] ModeRaise   = 2'd0;
  localparam logic [1:0] ModeLower   = 2'd1;
  localparam logic [1:0] ModeFlatten = 2'd2;
  localparam logic [1:0] ModeSpare   = 2'd3;

  localparam logic [1:0] RegRadius   = 2'd0;
  localparam logic [1:0] RegStrength = 2'd1;
  localparam logic [1:0] RegMode     = 2'd2;
  localparam logic [1:0] RegSpare    = 2'd3;

  // per-vertex data that rides along the arithmetic pipeline
  typedef struct packed {
    logic signed [CoordW-1:0] height;
    logic [TimeW-1:0]         dt;
    logic                     hit;
  } side_t;

endpackage

[hdl/tbs_isqrt.sv]
// pipelined integer square root, one result bit per register stage
// depends on tbs_pkg
module tbs_isqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [63:0]           val_i,
  input  tbs_pkg::side_t        side_i,
  output logic                  vld_o,
  output logic [31:0]           root_o,
  output tbs_pkg::side_t        side_o
);
  import tbs_pkg::*;

  logic        vld_q  [SqrtSteps];
  logic [32:0] rem_q  [SqrtSteps];
  logic [31:0] root_q [SqrtSteps];
  logic [63:0] val_q  [SqrtSteps];
  side_t       side_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic        p_vld;
    logic [32:0] p_rem;
    logic [31:0] p_root;
    logic [63:0] p_val;
    side_t       p_side;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;
    logic [32:0] rem_d;
    logic [31:0] root_d;

    if (k == 0) begin : g_first
      assign p_vld  = vld_i;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_val  = val_i;
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
      assign p_val  = val_q[k-1];
      assign p_side = side_q[k-1];
    end

    always_comb begin
      rem_sh = {p_rem, p_val[63:62]};
      trial  = {1'b0, p_root, 2'b01};
      ge     = (rem_sh >= trial);
      rem_d  = ge ? 33'(rem_sh - trial) : rem_sh[32:0];
      root_d = {p_root[30:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        val_q[k]  <= {p_val[61:0], 2'b00};
        side_q[k] <= p_side;
      end
    end
  end

  assign vld_o  = vld_q[SqrtSteps-1];
  assign root_o = root_q[SqrtSteps-1];
  assign side_o = side_q[SqrtSteps-1];

endmodule

[hdl/tbs_div.sv]
// pipelined restoring divider, one quotient bit per register stage
// depends on tbs_pkg; quotient must fit QuotW bits
module tbs_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [62:0]           num_i,
  input  logic [31:0]           den_i,
  input  tbs_pkg::side_t        side_i,
  output logic                  vld_o,
  output logic [30:0]           quot_o,
  output tbs_pkg::side_t        side_o
);
  import tbs_pkg::*;

  logic        vld_q  [QuotW];
  logic [31:0] rem_q  [QuotW];
  logic [30:0] quo_q  [QuotW];
  logic [30:0] low_q  [QuotW];
  side_t       side_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic        p_vld;
    logic [31:0] p_rem;
    logic [30:0] p_quo;
    logic [30:0] p_low;
    side_t       p_side;
    logic [32:0] rem_sh;
    logic        ge;
    logic [31:0] rem_d;

    if (k == 0) begin : g_first
      assign p_vld  = vld_i;
      assign p_rem  = num_i[62:31];
      assign p_quo  = '0;
      assign p_low  = num_i[30:0];
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_quo  = quo_q[k-1];
      assign p_low  = low_q[k-1];
      assign p_side = side_q[k-1];
    end

    always_comb begin
      rem_sh = {p_rem, p_low[30]};
      ge     = (rem_sh >= {1'b0, den_i});
      rem_d  = ge ? 32'(rem_sh - {1'b0, den_i}) : rem_sh[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= {p_quo[29:0], ge};
        low_q[k]  <= {p_low[29:0], 1'b0};
        side_q[k] <= p_side;
      end
    end
  end

  assign vld_o  = vld_q[QuotW-1];
  assign quot_o = quo_q[QuotW-1];
  assign side_o = side_q[QuotW-1];

endmodule

[hdl/terrain_brush_sculpt.sv]
// terrain brush sculpt top level: distance, falloff and height update pipeline
// depends on tbs_pkg, tbs_isqrt, tbs_div
// One vertex is accepted per clock; its result leaves the last of 69 register stages
// (offsets, squares, sum and radius test, 32 square-root stages, falloff product, 31
// divider stages, time scaling and the output register holding the height update);
// the whole pipeline advances together and holds while the output waits, so a steady
// stream runs at one vertex per cycle. Brush registers are written through the cfg
// port by the user only while no vertex is in flight; the block does not enforce it.
module terrain_brush_sculpt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_x, vertex_z, vertex_height, centre_x, centre_z, elapsed_time, pad
  input  logic [183:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_height
  output logic [31:0]  m_axis_tdata,
  // sculpted
  output logic         m_axis_tuser
);
  import tbs_pkg::*;

  logic [RegW-1:0] radius_q, strength_q;
  logic [1:0]      mode_q;
  logic [61:0]     rr_q;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= 31'd327680;
      strength_q <= 31'd327680;
      mode_q     <= ModeRaise;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRadius:   radius_q   <= cfg_data_i[30:0];
        RegStrength: strength_q <= cfg_data_i[30:0];
        RegMode:     mode_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q <= radius_q * radius_q;
  end

  // stage a: axis offsets
  logic signed [32:0] dx, dz;
  logic [32:0]        adx, adz;
  side_t              a_side_d;
  always_comb begin
    dx  = {s_axis_tdata[31], s_axis_tdata[31:0]} - {s_axis_tdata[127], s_axis_tdata[127:96]};
    dz  = {s_axis_tdata[63], s_axis_tdata[63:32]} - {s_axis_tdata[159], s_axis_tdata[159:128]};
    adx = dx[32] ? 33'(-dx) : dx;
    adz = dz[32] ? 33'(-dz) : dz;
    a_side_d.height = s_axis_tdata[95:64];
    a_side_d.dt     = s_axis_tdata[176:160];
    // far vertices are out for any radius
    a_side_d.hit    = (adx[32:31] == 2'b00) && (adz[32:31] == 2'b00);
  end

  logic        a_vld_q, b_vld_q, c_vld_q;
  logic [30:0] a_ax_q, a_az_q;
  side_t       a_side_q, b_side_q, c_side_q;
  logic [61:0] b_sqx_q, b_sqz_q;
  logic [62:0] c_sum_q;
  logic [62:0] b_sum;
  side_t       c_side_d;
  assign b_sum = {1'b0, b_sqx_q} + {1'b0, b_sqz_q};

  always_comb begin
    c_side_d     = b_side_q;
    c_side_d.hit = b_side_q.hit && (b_sum < {1'b0, rr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q   <= adx[30:0];
      a_az_q   <= adz[30:0];
      a_side_q <= a_side_d;
      b_sqx_q  <= a_ax_q * a_ax_q;
      b_sqz_q  <= a_az_q * a_az_q;
      b_side_q <= a_side_q;
      c_sum_q  <= b_sum;
      c_side_q <= c_side_d;
    end
  end

  logic        s_vld;
  logic [31:0] s_root;
  side_t       s_side;

  tbs_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (c_vld_q),
    .val_i  ({1'b0, c_sum_q}),
    .side_i (c_side_q),
    .vld_o  (s_vld),
    .root_o (s_root),
    .side_o (s_side)
  );

  // stage d: strength * (2r - d)
  logic [31:0] two_r;
  logic        d_vld_q;
  logic [62:0] d_prod_q;
  side_t       d_side_q;
  assign two_r = {radius_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_prod_q <= strength_q * (two_r - s_root);
      d_side_q <= s_side;
    end
  end

  logic        q_vld;
  logic [30:0] q_quot;
  side_t       q_side;

  tbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d_vld_q),
    .num_i  (d_prod_q),
    .den_i  (two_r),
    .side_i (d_side_q),
    .vld_o  (q_vld),
    .quot_o (q_quot),
    .side_o (q_side)
  );

  // stage e: scale by frame time
  logic        e_vld_q;
  logic [47:0] e_stp_q;
  side_t       e_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_stp_q  <= q_quot * q_side.dt;
      e_side_q <= q_side;
    end
  end

  // stage f: height update with saturation
  logic signed [33:0] h_ext, step_ext, upd;
  logic [31:0]        new_h;
  always_comb begin
    h_ext    = {{2{e_side_q.height[31]}}, e_side_q.height};
    step_ext = {2'b00, e_stp_q[47:16]};
    upd      = h_ext;
    if (e_side_q.hit) begin
      unique case (mode_q)
        ModeRaise:   upd = h_ext + step_ext;
        ModeLower:   upd = h_ext - step_ext;
        ModeFlatten: upd = '0;
        default:     upd = h_ext;
      endcase
    end
    if (upd > 34'sd2147483647) begin
      new_h = 32'h7fff_ffff;
    end else if (upd < -34'sd2147483648) begin
      new_h = 32'h8000_0000;
    end else begin
      new_h = upd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= new_h;
      m_axis_tuser <= e_side_q.hit;
    end
  end

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser && mode_q == ModeFlatten) |-> (m_axis_tdata == '0))
    else $error("flattened vertex not at zero height");

  a_root_in_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_vld && s_side.hit) |-> (s_root < {1'b0, radius_q}))
    else $error("distance of inside vertex not below radius");

endmodule

[tb/tbs_checker.sv]
// checker for terrain_brush_sculpt: watches the cfg, vertex and result channels
// depends on tbs_pkg; predicts every height update and compares it in order
module tbs_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [183:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tbs_pkg::*;

  typedef struct {
    logic [31:0] height;
    logic        sculpted;
  } height_upd_t;

  height_upd_t      height_q[$];
  logic [RegW-1:0]  radius;
  logic [RegW-1:0]  strength;
  logic [1:0]       mode;

  assign pending_o = height_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic height_upd_t sculpt_vertex(logic [183:0] d);
    height_upd_t     e;
    longint          vx, vz, h, cx, cz, ax, az, result, step;
    longint unsigned sum, r, span, two_r, a, dt;
    vx = longint'($signed(d[31:0]));
    vz = longint'($signed(d[63:32]));
    h  = longint'($signed(d[95:64]));
    cx = longint'($signed(d[127:96]));
    cz = longint'($signed(d[159:128]));
    dt = longint'(d[176:160]);
    ax = vx - cx;
    if (ax < 0) ax = -ax;
    az = vz - cz;
    if (az < 0) az = -az;
    r  = longint'(radius);
    result     = h;
    e.sculpted = 1'b0;
    // offsets of 2^31 or more are always outside
    if (ax < 64'sh8000_0000 && az < 64'sh8000_0000) begin
      sum = ax * ax + az * az;
      if (sum < r * r) begin
        e.sculpted = 1'b1;
        span  = int_sqrt(sum);
        two_r = 2 * r;
        a     = (longint'(strength) * (two_r - span)) / two_r;
        step  = longint'((a * dt) >> 16);
        case (mode)
          ModeRaise:   result = h + step;
          ModeLower:   result = h - step;
          ModeFlatten: result = 0;
          default:     result = h;
        endcase
      end
    end
    if (result > 64'sd2147483647) result = 64'sd2147483647;
    if (result < -64'sd2147483648) result = -64'sd2147483648;
    e.height = result[31:0];
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    height_upd_t e;
    if (!rst_ni) begin
      radius   <= 31'd327680;
      strength <= 31'd327680;
      mode     <= ModeRaise;
      errors_o <= 0;
      height_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegRadius:   radius   <= cfg_data_i[RegW-1:0];
          RegStrength: strength <= cfg_data_i[RegW-1:0];
          RegMode:     mode     <= cfg_data_i[1:0];
          default:     ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) height_q.push_back(sculpt_vertex(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (height_q.size() == 0) begin
          $display("%0t: result with no request pending: height %h sculpted %b",
                   $time, m_axis_tdata, m_axis_tuser);
          errors_o <= errors_o + 1;
        end else begin
          e = height_q.pop_front();
          if (e.height !== m_axis_tdata || e.sculpted !== m_axis_tuser) begin
            $display("%0t: mismatch: expected height %h sculpted %b, got height %h sculpted %b",
                     $time, e.height, e.sculpted, m_axis_tdata, m_axis_tuser);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

[tb/tb_terrain_brush_sculpt.sv]
// testbench top for terrain_brush_sculpt: clock, reset, stimulus and verdict
// depends on tbs_pkg, terrain_brush_sculpt and tbs_checker
module tb_terrain_brush_sculpt;
  timeunit 1ns;
  timeprecision 1ps;
  import tbs_pkg::*;

  localparam int DrainCycles = 100;
  localparam int StallLimit  = 3000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;
  int           errors, pending;

  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;
  int           quiet_cycles = 0;
  logic [30:0]  cur_radius = 31'd327680;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  terrain_brush_sculpt u_dut (.*);

  tbs_checker u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  // result side: random stall bursts, plus one long counted hold-off on request
  always @(negedge clk_i) begin
    int n;
    if (hold_req) begin
      m_axis_tready = 1'b0;
      repeat (400) @(negedge clk_i);
      hold_req = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      n = $urandom_range(1, 6);
      repeat (n - 1) @(negedge clk_i);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || hold_req)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL terrain_brush_sculpt");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == RegRadius) cur_radius = val[30:0];
  endtask

  task automatic send_vertex(logic [31:0] vx, logic [31:0] vz, logic [31:0] h,
                             logic [31:0] cx, logic [31:0] cz, logic [16:0] dt);
    int n;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, dt, cz, cx, h, vz, vx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // mostly vertices placed within reach of the brush, the rest anywhere
  task automatic send_random();
    logic [31:0] vx, vz, dx, dz;
    logic [16:0] dt;
    vx = $urandom();
    vz = $urandom();
    dt = ($urandom_range(0, 3) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536));
    if ($urandom_range(0, 9) < 7) begin
      dx = $urandom_range(0, cur_radius);
      dz = $urandom_range(0, cur_radius);
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dz = -dz;
      send_vertex(vx, vz, $urandom(), vx - dx, vz - dz, dt);
    end else begin
      send_vertex(vx, vz, $urandom(), $urandom(), $urandom(), dt);
    end
  endtask

  initial begin
    logic [30:0] rad[8];
    logic [30:0] str[8];
    logic [1:0]  md[8];
    rad = '{31'd327680, 31'd0, 31'd1, 31'h7fffffff, 31'h7fffffff, 31'd655360, 31'd65536, 31'd0};
    str = '{31'd327680, 31'h7fffffff, 31'd1, 31'h7fffffff, 31'd0, 31'h7fffffff, 31'd200000, 31'd0};
    md  = '{ModeRaise, ModeLower, ModeFlatten, ModeRaise, ModeLower, ModeSpare, ModeLower,
            ModeRaise};
    rad[7] = 31'($urandom());
    str[7] = 31'($urandom());

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed vertices under the reset brush (radius 5.0, strength 5.0, raise)
    send_vertex(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd65536);           // brush centre
    send_vertex(32'd0, 32'd0, 32'h7fffffff, 32'd0, 32'd0, 17'h1ffff);    // saturate high
    send_vertex(32'd327680, 32'd0, 32'd5, 32'd0, 32'd0, 17'd65536);      // exactly on radius
    send_vertex(32'd327679, 32'd0, 32'd5, 32'd0, 32'd0, 17'd65536);      // just inside
    send_vertex(32'h7fffffff, 32'd0, 32'd1, 32'h80000000, 32'd0, 17'd1); // far vertex
    send_vertex(32'd0, 32'h80000000, 32'd1, 32'd0, 32'h7fffffff, 17'd1);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 17'd0);
    send_vertex(32'hffffffff, 32'hffffffff, 32'hfffffff0, 32'd0, 32'd0, 17'd70000);
    send_vertex(32'd100000, 32'd100000, 32'd0, 32'd0, 32'd0, 17'd32768);
    wait_drained();
    write_reg(RegSpare, 32'hffffffff);       // unknown index is ignored
    write_reg(RegMode, {30'd0, ModeLower});
    send_vertex(32'd0, 32'd0, 32'h80000000, 32'd0, 32'd0, 17'h1ffff);    // saturate low
    send_vertex(32'd10, 32'd20, 32'h12345678, 32'd0, 32'd0, 17'd65536);
    send_vertex(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 17'd0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_reg(RegRadius, {$urandom_range(0, 1) == 1, rad[p]});
      write_reg(RegStrength, {1'b0, str[p]});
      write_reg(RegMode, {30'($urandom()), md[p]});
      if (p == 7) idle_on = 1'b0;
      for (int i = 0; i < 116; i++) begin
        if (p == 2 && i == 10) hold_req = 1'b1;
        if (p == 4 && i == 60) while (pending != 0) @(negedge clk_i);
        send_random();
      end
      s_axis_tvalid = 1'b0;
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS terrain_brush_sculpt");
    end else begin
      $display("FAIL terrain_brush_sculpt");
    end
    $finish;
  end

endmodule

[terrain_brush_sculpt.f]
hdl/tbs_pkg.sv
hdl/tbs_isqrt.sv
hdl/tbs_div.sv
hdl/terrain_brush_sculpt.sv
tb/tbs_checker.sv
tb/tb_terrain_brush_sculpt.sv
